// ----- design/ndg_pkg.sv -----
// ----------------------------------------------------------------------------
// ndg_pkg
// Shared types and constants for the N-dimensional gather address generator.
// ----------------------------------------------------------------------------
package ndg_pkg;

	localparam int MAX_DIMS_DEF    = 8;
	localparam int INDEX_DEPTH_DEF = 256;
	localparam int ADDR_WIDTH_DEF  = 32;
	localparam int MAX_BURST_DEF   = 16;

	localparam int CFG_W  = 5;
	localparam int CIDX_W = 2;

	typedef enum logic [1:0] {
		CFG_NUM_DIMS  = 2'd0,
		CFG_COLON_DIM = 2'd1,
		CFG_BURST_LEN = 2'd2,
		CFG_UNUSED    = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OP_SET_SIZES = 2'd0,
		OP_WR_INDEX  = 2'd1,
		OP_RESTART   = 2'd2,
		OP_NEXT      = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STRIDE,
		ST_WALK,
		ST_DRAIN,
		ST_SCALE,
		ST_BURST
	} state_t;

	typedef struct packed {
		logic load_sizes;
		logic write_index;
		logic restart;
		logic stride_step;
		logic walk_start;
		logic walk_issue;
		logic scale;
		logic burst_step;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic stride_last;
		logic walk_last;
		logic pipe_empty;
		logic burst_last;
	} status_t;

endpackage

// ----- design/ndg_ctrl.sv -----
// ----------------------------------------------------------------------------
// ndg_ctrl
// Sequencer: decodes requests and steps the datapath through stride build,
// dimension walk, scaling and burst output.
// ----------------------------------------------------------------------------
module ndg_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       op,
	input  ndg_pkg::status_t status,
	output ndg_pkg::cmd_t    cmd,
	output logic             busy
);

	ndg_pkg::state_t state_q, state_d;
	logic            accept;

	assign accept = start && (state_q == ndg_pkg::ST_IDLE);
	assign busy   = (state_q != ndg_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ndg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ndg_pkg::ST_IDLE: begin
				if (accept) begin
					case (ndg_pkg::op_t'(op))
						ndg_pkg::OP_SET_SIZES: cmd.load_sizes = 1'b1;
						ndg_pkg::OP_WR_INDEX:  cmd.write_index = 1'b1;
						ndg_pkg::OP_RESTART: begin
							cmd.restart = 1'b1;
							state_d     = ndg_pkg::ST_STRIDE;
						end
						ndg_pkg::OP_NEXT: begin
							// drop the request once the output is complete
							if (!status.done) begin
								cmd.walk_start = 1'b1;
								state_d        = ndg_pkg::ST_WALK;
							end
						end
						default: state_d = ndg_pkg::ST_IDLE;
					endcase
				end
			end
			ndg_pkg::ST_STRIDE: begin
				cmd.stride_step = 1'b1;
				if (status.stride_last) state_d = ndg_pkg::ST_IDLE;
			end
			ndg_pkg::ST_WALK: begin
				cmd.walk_issue = 1'b1;
				if (status.walk_last) state_d = ndg_pkg::ST_DRAIN;
			end
			ndg_pkg::ST_DRAIN: begin
				if (status.pipe_empty) state_d = ndg_pkg::ST_SCALE;
			end
			ndg_pkg::ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ndg_pkg::ST_BURST;
			end
			ndg_pkg::ST_BURST: begin
				cmd.burst_step = 1'b1;
				if (status.burst_last) state_d = ndg_pkg::ST_IDLE;
			end
			default: state_d = ndg_pkg::ST_IDLE;
		endcase
	end

	a_scale_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scale |-> $past(state_q == ndg_pkg::ST_DRAIN) && $past(status.pipe_empty))
		else $error("scale without an empty pipeline");
	a_burst_follows_scale: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scale |=> cmd.burst_step)
		else $error("burst did not follow scale");
	a_walk_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_start |=> cmd.walk_issue)
		else $error("walk did not begin");

endmodule

// ----- design/ndg_datapath.sv -----
// ----------------------------------------------------------------------------
// ndg_datapath
// Extent, stride and counter tables, index memory, strided multiply and
// accumulate, burst address output.
// ----------------------------------------------------------------------------
module ndg_datapath #(
	parameter int MAX_DIMS    = ndg_pkg::MAX_DIMS_DEF,
	parameter int INDEX_DEPTH = ndg_pkg::INDEX_DEPTH_DEF,
	parameter int ADDR_WIDTH  = ndg_pkg::ADDR_WIDTH_DEF,
	parameter int MAX_BURST   = ndg_pkg::MAX_BURST_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ndg_pkg::cmd_t             cmd,
	output ndg_pkg::status_t          status,
	input  logic                      wr_en,
	input  logic [ndg_pkg::CIDX_W-1:0] wr_index,
	input  logic [ndg_pkg::CFG_W-1:0] wr_data,
	input  logic [2:0]                dim,
	input  logic [7:0]                position,
	input  logic [15:0]               index_value,
	input  logic [15:0]               out_size,
	input  logic [15:0]               src_size,
	output logic                      strobe,
	output logic [ADDR_WIDTH-1:0]     source_address,
	output logic                      last_of_burst,
	output logic                      last_element
);

	localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int NW = $clog2(MAX_DIMS + 1);
	localparam int SW = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1;
	localparam int MD = MAX_DIMS * INDEX_DEPTH;
	localparam int MW = $clog2(MD);
	localparam int BW = (MAX_BURST > 1) ? $clog2(MAX_BURST + 1) : 1;

	logic [3:0] num_q;
	logic [3:0] colon_q;
	logic [4:0] burst_q;

	logic [15:0]           out_ext_q [MAX_DIMS];
	logic [15:0]           src_ext_q [MAX_DIMS];
	logic [ADDR_WIDTH-1:0] stride_q  [MAX_DIMS];
	logic [15:0]           cnt_q     [MAX_DIMS];
	logic [SW-1:0]         slot_q    [MAX_DIMS];
	logic                  done_q;

	logic [15:0] idx_mem [MD];

	logic [DW-1:0] sd_q;
	logic [DW-1:0] wd_q;
	logic [BW-1:0] k_q;

	logic [15:0]           rd_s1;
	logic [15:0]           cnt_s1;
	logic [DW-1:0]         dim_s1;
	logic                  colon_s1;
	logic                  valid_s1;
	logic [ADDR_WIDTH-1:0] prod_s2;
	logic                  valid_s2;
	logic [ADDR_WIDTH-1:0] acc_q;
	logic [ADDR_WIDTH-1:0] base_q;
	logic                  last_q;

	logic [NW-1:0]         nd;
	logic [DW-1:0]         nd_m1;
	logic [BW-1:0]         bl;
	logic [ADDR_WIDTH-1:0] v;
	logic                  dim_ok;
	logic [DW-1:0]         dim_i;
	logic [MW-1:0]         wr_addr;
	logic [MW-1:0]         rd_addr;
	logic [MAX_DIMS-1:0]   in_use;
	logic [MAX_DIMS-1:0]   wrap;
	logic [MAX_DIMS:0]     carry;
	logic                  last_now;

	always_comb begin
		if (num_q == '0) nd = NW'(1);
		else if (32'(num_q) > MAX_DIMS) nd = NW'(MAX_DIMS);
		else nd = NW'(num_q);
		nd_m1 = DW'(nd - NW'(1));
		if (burst_q == '0) bl = BW'(1);
		else if (32'(burst_q) > MAX_BURST) bl = BW'(MAX_BURST);
		else bl = BW'(burst_q);
	end

	assign dim_ok  = 32'(dim) < MAX_DIMS;
	assign dim_i   = DW'(dim);
	assign wr_addr = MW'(MW'(dim_i) * MW'(INDEX_DEPTH) + MW'(position));
	assign rd_addr = MW'(MW'(wd_q) * MW'(INDEX_DEPTH) + MW'(slot_q[wd_q]));

	// Odometer step: a dimension advances when every lower one wraps.
	always_comb begin
		carry[0] = 1'b1;
		for (int d = 0; d < MAX_DIMS; d++) begin
			in_use[d]    = 32'(d) < 32'(nd);
			wrap[d]      = (17'(cnt_q[d]) + 17'd1) >=
				((out_ext_q[d] == '0) ? 17'd1 : 17'(out_ext_q[d]));
			carry[d + 1] = carry[d] & (wrap[d] | ~in_use[d]);
		end
		last_now = carry[MAX_DIMS];
	end

	assign v = colon_s1 ? ADDR_WIDTH'(cnt_s1) : ADDR_WIDTH'(rd_s1) - ADDR_WIDTH'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q   <= 4'd2;
			colon_q <= 4'd8;
			burst_q <= 5'd1;
		end else if (wr_en) begin
			case (ndg_pkg::cfg_idx_t'(wr_index))
				ndg_pkg::CFG_NUM_DIMS:  num_q   <= wr_data[3:0];
				ndg_pkg::CFG_COLON_DIM: colon_q <= wr_data[3:0];
				ndg_pkg::CFG_BURST_LEN: burst_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write_index && dim_ok && (32'(position) < INDEX_DEPTH)) begin
			idx_mem[wr_addr] <= index_value;
		end
		rd_s1 <= idx_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < MAX_DIMS; d++) begin
				out_ext_q[d] <= '1;
				src_ext_q[d] <= '1;
				stride_q[d]  <= '1;
				cnt_q[d]     <= '0;
				slot_q[d]    <= '0;
			end
			done_q   <= 1'b0;
			sd_q     <= '0;
			wd_q     <= '0;
			k_q      <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			strobe   <= 1'b0;
		end else begin
			valid_s1 <= cmd.walk_issue;
			valid_s2 <= valid_s1;
			strobe   <= cmd.burst_step;
			if (cmd.load_sizes && dim_ok) begin
				out_ext_q[dim_i] <= out_size;
				src_ext_q[dim_i] <= src_size;
			end
			if (cmd.restart) begin
				stride_q[0] <= ADDR_WIDTH'(1);
				for (int d = 0; d < MAX_DIMS; d++) begin
					cnt_q[d]  <= '0;
					slot_q[d] <= '0;
				end
				done_q <= 1'b0;
				sd_q   <= DW'(1);
			end
			if (cmd.stride_step) begin
				stride_q[sd_q] <= ADDR_WIDTH'(stride_q[sd_q - DW'(1)] *
					ADDR_WIDTH'(src_ext_q[sd_q - DW'(1)]));
				sd_q <= sd_q + DW'(1);
			end
			if (cmd.walk_start) wd_q <= '0;
			if (cmd.walk_issue) wd_q <= wd_q + DW'(1);
			if (cmd.scale) begin
				for (int d = 0; d < MAX_DIMS; d++) begin
					if (in_use[d] && carry[d]) begin
						if (wrap[d]) begin
							cnt_q[d]  <= '0;
							slot_q[d] <= '0;
						end else begin
							cnt_q[d]  <= cnt_q[d] + 16'd1;
							slot_q[d] <= (32'(slot_q[d]) == INDEX_DEPTH - 1) ? '0 :
								slot_q[d] + SW'(1);
						end
					end
				end
				if (last_now) done_q <= 1'b1;
				k_q <= '0;
			end
			if (cmd.burst_step) k_q <= k_q + BW'(1);
		end
	end

	always_ff @(posedge clk) begin
		cnt_s1   <= cnt_q[wd_q];
		dim_s1   <= wd_q;
		colon_s1 <= (4'(wd_q) == colon_q);
		prod_s2  <= ADDR_WIDTH'(v * stride_q[dim_s1]);
		if (cmd.walk_start) acc_q <= '0;
		else if (valid_s2) acc_q <= acc_q + prod_s2;
		if (cmd.scale) begin
			base_q <= ADDR_WIDTH'(acc_q * ADDR_WIDTH'(bl));
			last_q <= last_now;
		end
		if (cmd.burst_step) begin
			source_address <= base_q + ADDR_WIDTH'(k_q);
			last_of_burst  <= (k_q == bl - BW'(1));
			last_element   <= last_q;
		end
	end

	assign status.done        = done_q;
	assign status.stride_last = (32'(sd_q) == MAX_DIMS - 1);
	assign status.walk_last   = (wd_q == nd_m1);
	assign status.pipe_empty  = !valid_s1 && !valid_s2;
	assign status.burst_last  = (k_q == bl - BW'(1));

endmodule

// ----- design/nd_gather_address_generator_top.sv -----
// ----------------------------------------------------------------------------
// nd_gather_address_generator_top
// Source address generator for an N-dimensional array subset gather.
// ----------------------------------------------------------------------------
// One request at a time; busy is high while it is worked on. Set-size and
// index-write requests finish in the cycle they are taken, and busy stays low.
// A restart keeps busy high while the strides are built, one stride product
// per cycle through the single stride multiplier. A next request keeps busy
// high while it is worked on: one index memory read per dimension, a drain
// of the read, multiply and accumulate stages, a scaling step, then one
// burst step per address of the burst. Results follow one per cycle on
// strobe. A next request after the last element is taken and dropped, and
// busy stays low. The receiver cannot stall: each result is valid for
// exactly the one cycle that strobe is high. The last result of a request
// appears in the first cycle in which busy is low again.
module nd_gather_address_generator_top #(
	parameter int MAX_DIMS    = ndg_pkg::MAX_DIMS_DEF,
	parameter int INDEX_DEPTH = ndg_pkg::INDEX_DEPTH_DEF,
	parameter int ADDR_WIDTH  = ndg_pkg::ADDR_WIDTH_DEF,
	parameter int MAX_BURST   = ndg_pkg::MAX_BURST_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 op,
	input  logic [2:0]                 dim,
	input  logic [7:0]                 position,
	input  logic [15:0]                index_value,
	input  logic [15:0]                out_size,
	input  logic [15:0]                src_size,
	input  logic                       wr_en,
	input  logic [ndg_pkg::CIDX_W-1:0] wr_index,
	input  logic [ndg_pkg::CFG_W-1:0]  wr_data,
	output logic                       strobe,
	output logic [ADDR_WIDTH-1:0]      source_address,
	output logic                       last_of_burst,
	output logic                       last_element
);

	ndg_pkg::cmd_t    cmd;
	ndg_pkg::status_t status;

	ndg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	ndg_datapath #(
		.MAX_DIMS    (MAX_DIMS),
		.INDEX_DEPTH (INDEX_DEPTH),
		.ADDR_WIDTH  (ADDR_WIDTH),
		.MAX_BURST   (MAX_BURST)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.dim            (dim),
		.position       (position),
		.index_value    (index_value),
		.out_size       (out_size),
		.src_size       (src_size),
		.strobe         (strobe),
		.source_address (source_address),
		.last_of_burst  (last_of_burst),
		.last_element   (last_element)
	);

endmodule

// ----- tb/nd_gather_address_generator_top_tb.sv -----
// ----------------------------------------------------------------------------
// nd_gather_address_generator_top_tb
// Self-checking bench for the gather address generator. Phases of size,
// index-table and restart requests followed by element walks run under
// several register settings. A behavioural predictor forms the expected
// addresses and flags, and a monitor checks every strobed result in order.
// ----------------------------------------------------------------------------
module nd_gather_address_generator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NDIMS     = 8;
	localparam int TBL_DEPTH = 256;
	localparam int NBURST    = 16;
	localparam int LIMIT     = 1000000;

	typedef struct {
		ndg_pkg::op_t op;
		logic [2:0]   dim;
		logic [7:0]   pos;
		logic [15:0]  idx;
		logic [15:0]  osz;
		logic [15:0]  ssz;
	} gather_req_t;

	typedef struct {
		logic [31:0] addr;
		logic        lob;
		logic        le;
	} fetch_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] op = '0;
	logic [2:0] dim = '0;
	logic [7:0] position = '0;
	logic [15:0] index_value = '0;
	logic [15:0] out_size = '0;
	logic [15:0] src_size = '0;
	logic wr_en = 1'b0;
	logic [ndg_pkg::CIDX_W-1:0] wr_index = '0;
	logic [ndg_pkg::CFG_W-1:0] wr_data = '0;
	logic strobe;
	logic [31:0] source_address;
	logic last_of_burst;
	logic last_element;

	// predictor state
	logic [15:0] p_out_ext [NDIMS];
	logic [15:0] p_src_ext [NDIMS];
	logic [31:0] p_stride [NDIMS];
	logic [15:0] p_count [NDIMS];
	logic [15:0] p_index [NDIMS][TBL_DEPTH];
	logic        p_done;
	logic [3:0]  p_num_dims;
	logic [3:0]  p_colon;
	logic [4:0]  p_burst;

	gather_req_t pending_q[$];
	fetch_t      fetch_q[$];
	gather_req_t cur;
	int gap = 0;
	bit quiet = 0;
	int errors = 0;
	int cycles = 0;
	int requests_done = 0;
	int walks_done = 0;
	int fetches_seen = 0;
	int phases = 0;

	nd_gather_address_generator_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op), .dim(dim),
		.position(position), .index_value(index_value), .out_size(out_size),
		.src_size(src_size), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.strobe(strobe), .source_address(source_address),
		.last_of_burst(last_of_burst), .last_element(last_element)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic report(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic void predict_gather(input gather_req_t r);
		int nd;
		int bl;
		logic [31:0] acc;
		logic [31:0] v;
		logic [31:0] base;
		logic [16:0] c;
		logic [15:0] ext;
		bit last;
		fetch_t f;
		case (r.op)
			ndg_pkg::OP_SET_SIZES: begin
				p_out_ext[r.dim] = r.osz;
				p_src_ext[r.dim] = r.ssz;
			end
			ndg_pkg::OP_WR_INDEX: p_index[r.dim][r.pos] = r.idx;
			ndg_pkg::OP_RESTART: begin
				p_stride[0] = 32'd1;
				for (int d = 1; d < NDIMS; d++)
					p_stride[d] = p_stride[d-1] * {16'd0, p_src_ext[d-1]};
				for (int d = 0; d < NDIMS; d++)
					p_count[d] = '0;
				p_done = 1'b0;
			end
			default: begin
				if (p_done)
					return;
				nd = (p_num_dims == 0) ? 1 : (p_num_dims > NDIMS) ? NDIMS : p_num_dims;
				bl = (p_burst == 0) ? 1 : (p_burst > NBURST) ? NBURST : p_burst;
				acc = '0;
				last = 1;
				for (int d = 0; d < nd; d++) begin
					if (d == p_colon)
						v = {16'd0, p_count[d]};
					else
						v = {16'd0, p_index[d][p_count[d] % TBL_DEPTH]} - 32'd1;
					acc = acc + v * p_stride[d];
					ext = (p_out_ext[d] == 0) ? 16'd1 : p_out_ext[d];
					if ({1'b0, p_count[d]} + 17'd1 < {1'b0, ext})
						last = 0;
				end
				base = acc * bl;
				for (int k = 0; k < bl; k++) begin
					f.addr = base + k;
					f.lob = (k == bl - 1);
					f.le = last;
					fetch_q.push_back(f);
				end
				for (int d = 0; d < nd; d++) begin
					ext = (p_out_ext[d] == 0) ? 16'd1 : p_out_ext[d];
					c = {1'b0, p_count[d]} + 17'd1;
					if (c >= {1'b0, ext}) begin
						p_count[d] = '0;
					end else begin
						p_count[d] = c[15:0];
						break;
					end
				end
				if (last)
					p_done = 1'b1;
				walks_done++;
			end
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 9);
		if (quiet || r < 6)
			return 0;
		if (r < 9)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		automatic bit fire;
		automatic int g;
		if (!arst_n) begin
			start <= 1'b0;
			gap <= 0;
		end else begin
			fire = start && !busy;
			g = gap;
			if (fire) begin
				predict_gather(cur);
				requests_done++;
				g = pick_gap();
			end
			if (start && !fire) begin
				// hold the request until the block takes it
			end else if (g > 0) begin
				start <= 1'b0;
				gap <= g - 1;
			end else if (pending_q.size() > 0) begin
				cur = pending_q.pop_front();
				op <= cur.op;
				dim <= cur.dim;
				position <= cur.pos;
				index_value <= cur.idx;
				out_size <= cur.osz;
				src_size <= cur.ssz;
				start <= 1'b1;
				gap <= 0;
			end else begin
				start <= 1'b0;
				gap <= 0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		automatic fetch_t e;
		if (arst_n && strobe) begin
			fetches_seen++;
			if (fetch_q.size() == 0) begin
				report($sformatf("unexpected address %08h", source_address));
			end else begin
				e = fetch_q.pop_front();
				if (source_address !== e.addr)
					report($sformatf("address %08h, want %08h", source_address, e.addr));
				if (last_of_burst !== e.lob)
					report($sformatf("last_of_burst %b, want %b", last_of_burst, e.lob));
				if (last_element !== e.le)
					report($sformatf("last_element %b, want %b", last_element, e.le));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	task automatic push_req(input ndg_pkg::op_t o, input int d, input int p, input int iv,
			input int os, input int ss);
		gather_req_t r;
		r.op = o;
		r.dim = d[2:0];
		r.pos = p[7:0];
		r.idx = iv[15:0];
		r.osz = os[15:0];
		r.ssz = ss[15:0];
		pending_q.push_back(r);
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pending_q.size() != 0 || start || busy || fetch_q.size() != 0);
		// a restart or write may still be in flight with no result to show it
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(input ndg_pkg::cfg_idx_t idx, input int value);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value[ndg_pkg::CFG_W-1:0];
		case (idx)
			ndg_pkg::CFG_NUM_DIMS:  p_num_dims = value[3:0];
			ndg_pkg::CFG_COLON_DIM: p_colon = value[3:0];
			ndg_pkg::CFG_BURST_LEN: p_burst = value[4:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(input int nd, input int col, input int bl);
		write_reg(ndg_pkg::CFG_NUM_DIMS, nd);
		write_reg(ndg_pkg::CFG_COLON_DIM, col);
		write_reg(ndg_pkg::CFG_BURST_LEN, bl);
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	function automatic int pick_index();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return 0;
		if (r == 1)
			return 1;
		if (r == 2)
			return 16'hFFFF;
		return $urandom_range(1, 65535);
	endfunction

	// sizes, index tables for the dimensions that are read, restart, then a walk
	task automatic run_phase(input int nd, input int col, input int bl, input int maxext,
			input int walks);
		int ext [NDIMS];
		int os;
		int ss;
		int d;
		int eff;
		phases++;
		set_regs(nd, col, bl);
		eff = (nd == 0) ? 1 : (nd > NDIMS) ? NDIMS : nd;
		for (int i = 0; i < NDIMS; i++) begin
			if (maxext > TBL_DEPTH && i == 0)
				os = maxext;
			else if ($urandom_range(0, 7) == 0)
				os = 0;
			else
				os = $urandom_range(1, (maxext > 4) ? 4 : maxext);
			case ($urandom_range(0, 3))
				0: ss = 16'hFFFF;
				1: ss = 1;
				default: ss = $urandom_range(1, 65535);
			endcase
			ext[i] = (os == 0) ? 1 : os;
			push_req(ndg_pkg::OP_SET_SIZES, i, 0, 0, os, ss);
			if (i < eff && i != col) begin
				for (int p = 0; p < ext[i] && p < TBL_DEPTH; p++)
					push_req(ndg_pkg::OP_WR_INDEX, i, p, pick_index(), 0, 0);
			end
		end
		push_req(ndg_pkg::OP_RESTART, 0, 0, 0, 0, 0);
		for (int w = 0; w < walks; w++) begin
			case ($urandom_range(0, 19))
				0: begin
					d = $urandom_range(0, NDIMS - 1);
					push_req(ndg_pkg::OP_WR_INDEX, d, $urandom_range(0, (ext[d] > TBL_DEPTH) ?
						TBL_DEPTH - 1 : ext[d] - 1), pick_index(), 0, 0);
				end
				1: push_req(ndg_pkg::OP_RESTART, 0, 0, 0, 0, 0);
				default: ;
			endcase
			push_req(ndg_pkg::OP_NEXT, $urandom_range(0, 7), $urandom_range(0, 255),
				$urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535));
		end
		drain();
	endtask

	initial begin
		for (int d = 0; d < NDIMS; d++) begin
			p_out_ext[d] = '1;
			p_src_ext[d] = '1;
			p_stride[d] = '1;
			p_count[d] = '0;
		end
		p_done = 1'b0;
		p_num_dims = 4'd2;
		p_colon = 4'd8;
		p_burst = 5'd1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// register writes to the spare index change nothing
		write_reg(ndg_pkg::CFG_UNUSED, 5'h1F);
		@(posedge clk);
		wr_en <= 1'b0;

		quiet = 1;
		run_phase(1, 8, 1, 3, 5);
		run_phase(8, 0, 16, 2, 12);
		run_phase(0, 15, 0, 3, 6);
		quiet = 0;
		run_phase(15, 7, 31, 2, 10);
		run_phase(3, 1, 5, 4, 20);

		quiet = ($urandom_range(0, 3) == 0);
		run_phase($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 31),
			$urandom_range(1, 4), $urandom_range(8, 24));

		drain();
		$display("%0d phases, %0d requests, %0d element steps, %0d addresses checked",
			phases, requests_done, walks_done, fetches_seen);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", errors);
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
design/ndg_pkg.sv
design/ndg_ctrl.sv
design/ndg_datapath.sv
design/nd_gather_address_generator_top.sv
tb/nd_gather_address_generator_top_tb.sv
